/* rtl/mbd_pkg.sv */
// Package for the mipmap box downsampler: field widths, register indexes
// and the beat types of the pixel and result channels.
// No dependencies.
package mbd_pkg;

  localparam int CH_W         = 8;     // one color channel
  localparam int COORD_W      = 12;    // output coordinate, source row counter
  localparam int DIM_W        = 13;    // width / height registers
  localparam int SHIFT_W      = 4;     // block shift register
  localparam int CFG_IDX_W    = 2;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int CHANNEL_MAX  = 255;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BLOCK_SHIFT  = 2'd2
  } cfg_reg_t;

  // One source pixel
  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] alpha_in;
  } pixel_t;

  // One downsampled pixel
  typedef struct packed {
    logic [CH_W-1:0]    red_out;
    logic [CH_W-1:0]    green_out;
    logic [CH_W-1:0]    blue_out;
    logic [CH_W-1:0]    alpha_out;
    logic [COORD_W-1:0] out_column;
    logic [COORD_W-1:0] out_row;
    logic               frame_done;
  } result_t;

endpackage

/* rtl/mbd_stream_if.sv */
// Valid/ready stream interface used for the pixel and result channels.
// Beat type is a parameter; the types come from mbd_pkg.
interface mbd_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/mbd_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module mbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mipmap_box_downsample_top.sv */
// Mipmap box downsampler, top level. Uses mbd_pkg, mbd_stream_if, mbd_ram.
// Throughput: one pixel beat per clock from the read-add-write pass over the
// column-sum RAM; input waits only while the 3-entry result FIFO is backed up.
// A result is valid once its bottom-right pixel has been accepted, registered into
// stage 1 (registered RAM read, add) and pushed into the result FIFO.
// Reset (rst, sync): 256 x 256, shift 1, counters and FIFO cleared; sum RAM not.
module mipmap_box_downsample_top
  import mbd_pkg::*;
#(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_SHIFT = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  mbd_stream_if.sink           pixel,
  mbd_stream_if.source         result
);

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int SUM_W      = CH_W + 2 * MAX_SHIFT;
  localparam int MEM_W      = 4 * SUM_W;
  localparam int FIFO_DEPTH = 3;

  typedef struct packed {
    logic              first;
    logic              last;
    logic              done;
    logic [CW-1:0]     col;
    logic [COORD_W-1:0] row;
    pixel_t            pix;
  } s1_t;

  // Configuration registers
  logic [DIM_W-1:0]   width_raw;
  logic [DIM_W-1:0]   height_raw;
  logic [SHIFT_W-1:0] shift_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_raw  <= DIM_W'(256);
      height_raw <= DIM_W'(256);
      shift_raw  <= SHIFT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_raw  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_raw <= cfg_wdata;
        REG_BLOCK_SHIFT:  shift_raw  <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective (clamped) geometry
  logic [CW:0]        eff_w;
  logic [DIM_W-1:0]   eff_h;
  logic [SHIFT_W-1:0] sh;
  logic [CW-1:0]      col_mask;
  logic [COORD_W-1:0] row_mask;
  logic [CW:0]        out_w;
  logic [DIM_W-1:0]   out_h;

  always_comb begin
    if (width_raw == '0) eff_w = (CW+1)'(1);
    else if (int'(width_raw) > MAX_WIDTH) eff_w = (CW+1)'(MAX_WIDTH);
    else eff_w = (CW+1)'(width_raw);

    if (height_raw == '0) eff_h = DIM_W'(1);
    else if (int'(height_raw) > HEIGHT_LIMIT) eff_h = DIM_W'(HEIGHT_LIMIT);
    else eff_h = height_raw;

    if (int'(shift_raw) > MAX_SHIFT) sh = SHIFT_W'(MAX_SHIFT);
    else sh = shift_raw;

    col_mask = CW'((32'd1 << sh) - 32'd1);
    row_mask = COORD_W'((32'd1 << sh) - 32'd1);
    out_w    = eff_w >> sh;
    out_h    = eff_h >> sh;
  end

  // Source position and per-pixel decode
  logic [CW-1:0]      col_cnt;
  logic [COORD_W-1:0] row_cnt;
  logic [CW-1:0]      oc;
  logic [COORD_W-1:0] orow;
  logic [CW:0]        col_inc;
  logic [COORD_W:0]   row_inc;
  logic               in_range;
  logic               pix_first;
  logic               pix_last;
  logic               pix_done;
  logic               accept;

  assign oc        = col_cnt >> sh;
  assign orow      = row_cnt >> sh;
  assign col_inc   = {1'b0, col_cnt} + (CW+1)'(1);
  assign row_inc   = {1'b0, row_cnt} + (COORD_W+1)'(1);
  assign in_range  = ({1'b0, oc} < out_w) && ({1'b0, orow} < out_h);
  assign pix_first = ((col_cnt & col_mask) == '0) && ((row_cnt & row_mask) == '0);
  assign pix_last  = ((col_cnt & col_mask) == col_mask)
                  && ((row_cnt & row_mask) == row_mask);
  assign pix_done  = (({1'b0, oc} + (CW+1)'(1)) == out_w)
                  && (({1'b0, orow} + DIM_W'(1)) == out_h);
  assign accept    = pixel.valid && pixel.ready;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (col_inc >= eff_w) begin
        col_cnt <= '0;
        row_cnt <= (row_inc >= DIM_W'(eff_h)) ? '0 : row_inc[COORD_W-1:0];
      end else begin
        col_cnt <= col_inc[CW-1:0];
      end
    end
  end

  // Stage 1: RAM data arrives, accumulate and write back
  logic s1_v;
  s1_t  s1;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else     s1_v <= accept && in_range;
  end

  always_ff @(posedge clk) begin
    s1.first <= pix_first;
    s1.last  <= pix_last;
    s1.done  <= pix_done;
    s1.col   <= oc;
    s1.row   <= orow;
    s1.pix   <= pixel.data;
  end

  logic [MEM_W-1:0] rdata;
  logic [MEM_W-1:0] wdata;
  logic [MEM_W-1:0] base;
  logic             fwd_v;
  logic [CW-1:0]    fwd_addr;
  logic [MEM_W-1:0] fwd_data;

  mbd_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (s1_v),
    .waddr (s1.col),
    .wdata (wdata),
    .raddr (oc),
    .rdata (rdata)
  );

  // Forward the previous write when it hit the entry just read
  assign base = (fwd_v && (fwd_addr == s1.col)) ? fwd_data : rdata;

  logic [SUM_W-1:0] sum_r, sum_g, sum_b, sum_a;

  always_comb begin
    if (s1.first) begin
      sum_r = SUM_W'(s1.pix.red_in);
      sum_g = SUM_W'(s1.pix.green_in);
      sum_b = SUM_W'(s1.pix.blue_in);
      sum_a = SUM_W'(s1.pix.alpha_in);
    end else begin
      sum_r = base[4*SUM_W-1:3*SUM_W] + SUM_W'(s1.pix.red_in);
      sum_g = base[3*SUM_W-1:2*SUM_W] + SUM_W'(s1.pix.green_in);
      sum_b = base[2*SUM_W-1:SUM_W]   + SUM_W'(s1.pix.blue_in);
      sum_a = base[SUM_W-1:0]         + SUM_W'(s1.pix.alpha_in);
    end
    wdata = {sum_r, sum_g, sum_b, sum_a};
  end

  always_ff @(posedge clk) begin
    if (rst) fwd_v <= 1'b0;
    else     fwd_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    fwd_addr <= s1.col;
    fwd_data <= wdata;
  end

  // Average: drop 2*shift bits, limit to full scale
  function automatic logic [CH_W-1:0] avg_of(logic [SUM_W-1:0] s,
                                             logic [SHIFT_W-1:0] shv);
    logic [SUM_W-1:0] v;
    v = s >> {shv, 1'b0};
    return (v > SUM_W'(CHANNEL_MAX)) ? CH_W'(CHANNEL_MAX) : v[CH_W-1:0];
  endfunction

  result_t res;

  always_comb begin
    res.red_out    = avg_of(sum_r, sh);
    res.green_out  = avg_of(sum_g, sh);
    res.blue_out   = avg_of(sum_b, sh);
    res.alpha_out  = avg_of(sum_a, sh);
    res.out_column = COORD_W'(s1.col);
    res.out_row    = s1.row;
    res.frame_done = s1.done;
  end

  // Output FIFO; input is held off while a result could find it full
  result_t    fifo_mem [FIFO_DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  logic [2:0] pending;

  assign push    = s1_v && s1.last;
  assign pop     = result.valid && result.ready;
  assign pending = {1'b0, cnt} + {2'b0, push};

  assign pixel.ready  = (pending < 3'(FIFO_DEPTH));
  assign result.valid = (cnt != '0);
  assign result.data  = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == 2'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 2'd1;
      if (pop)  rd_ptr <= (rd_ptr == 2'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 2'd1;
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result never lands in a full FIFO
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (cnt < 2'(FIFO_DEPTH)))
    else $error("result pushed into full FIFO");

  // A block is both started and finished by one pixel only at shift zero
  a_single_pixel_block: assert property (@(posedge clk) disable iff (rst)
    (s1_v && s1.first && s1.last) |-> (sh == '0))
    else $error("first and last pixel coincide at nonzero shift");

  // Output valid only rises after a completed block
  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(push))
    else $error("result appeared without a completed block");
`endif

endmodule

/* sim/mipmap_box_downsample_top_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for mipmap_box_downsample_top: random pixel streams over many image
// sizes and block shifts, scored against an in-bench box-average predictor.
// Depends on mbd_pkg, mbd_stream_if and the RTL top level.
module mipmap_box_downsample_top_test;
  import mbd_pkg::*;

  localparam int MAX_W         = 4096;   // DUT default MAX_WIDTH
  localparam int MAX_SH        = 8;      // DUT default MAX_SHIFT
  localparam int SETTLE_CYCLES = 8;      // covers the registered result path
  localparam int DRAIN_LIMIT   = 4000;
  localparam int TIMEOUT_NS    = 1_000_000;
  localparam int RANDOM_PIXELS = 380;

  // Index past the register list: changes nothing, restarts the frame
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // One row of the directed script: a register write or a pixel beat
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [DIM_W-1:0]     value;
    pixel_t               px;
    logic                 typed;
    result_t              want;
  } step_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_wdata;

  mbd_stream_if #(.T(pixel_t))  pixel_ch ();
  mbd_stream_if #(.T(result_t)) result_ch ();

  mipmap_box_downsample_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pixel     (pixel_ch),
    .result    (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: shadow registers, raster position, per-column sums
  logic [DIM_W-1:0]   cur_width  = 13'd256;
  logic [DIM_W-1:0]   cur_height = 13'd256;
  logic [SHIFT_W-1:0] cur_shift  = 4'd1;
  int unsigned        col_pos    = 0;
  int unsigned        row_pos    = 0;
  int unsigned        col_sums [MAX_W][4];

  result_t owed_blocks [$];
  int      mismatches = 0;
  bit      steady = 1'b0;     // no idling on either side while set

  task automatic flag(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 100)
      $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic logic [CH_W-1:0] block_mean(input int unsigned sum, input int unsigned sh);
    int unsigned v;
    v = sum >> (2 * sh);
    return (v > CHANNEL_MAX) ? CH_W'(CHANNEL_MAX) : CH_W'(v);
  endfunction

  // Fold one accepted pixel into the column sums; returns 1 with the block
  // average when the pixel closes a block.
  function automatic bit fold_pixel(input pixel_t px, output result_t blk);
    int unsigned     w, h, sh, mask, out_w, out_h, oc, orow;
    logic [CH_W-1:0] chan [4];
    bit              hit;
    int              k;
    w = (cur_width == 0) ? 1 : (cur_width > MAX_W) ? MAX_W : cur_width;
    h = (cur_height == 0) ? 1 : (cur_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : cur_height;
    sh = (cur_shift > MAX_SH) ? MAX_SH : cur_shift;
    mask = (1 << sh) - 1;
    out_w = w >> sh;
    out_h = h >> sh;
    oc = col_pos >> sh;
    orow = row_pos >> sh;
    chan = '{px.red_in, px.green_in, px.blue_in, px.alpha_in};
    hit = 1'b0;
    blk = '0;
    if (oc < out_w && orow < out_h) begin
      // top-left pixel of a block loads the sums, the rest add
      for (k = 0; k < 4; k++) begin
        if ((col_pos & mask) == 0 && (row_pos & mask) == 0)
          col_sums[oc][k] = chan[k];
        else
          col_sums[oc][k] += chan[k];
      end
      if ((col_pos & mask) == mask && (row_pos & mask) == mask) begin
        blk.red_out    = block_mean(col_sums[oc][0], sh);
        blk.green_out  = block_mean(col_sums[oc][1], sh);
        blk.blue_out   = block_mean(col_sums[oc][2], sh);
        blk.alpha_out  = block_mean(col_sums[oc][3], sh);
        blk.out_column = oc[COORD_W-1:0];
        blk.out_row    = orow[COORD_W-1:0];
        blk.frame_done = (oc + 1 == out_w) && (orow + 1 == out_h);
        hit = 1'b1;
      end
    end
    // raster advance, wrapping at the image size
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h)
        row_pos = 0;
    end
    return hit;
  endfunction

  // Register write; leaves cfg_we high so writes can run back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_IMAGE_WIDTH:  cur_width = value;
      REG_IMAGE_HEIGHT: cur_height = value;
      REG_BLOCK_SHIFT:  cur_shift = value[SHIFT_W-1:0];
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
    @(negedge clk);
  endtask

  // Drive one pixel beat; returns at a falling edge with valid still high
  task automatic send_pixel(input pixel_t px, input bit typed, input result_t want);
    result_t blk;
    bit      hit;
    cfg_we <= 1'b0;
    while (!steady && $urandom_range(0, 99) < 26) begin
      pixel_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.data  <= px;
    do @(posedge clk); while (!pixel_ch.ready);
    hit = fold_pixel(px, blk);
    if (typed)
      owed_blocks.push_back(want);
    else if (hit)
      owed_blocks.push_back(blk);
    @(negedge clk);
  endtask

  // Stop the source, wait for every owed block, then let the pipe empty
  task automatic settle_idle();
    int n;
    pixel_ch.valid <= 1'b0;
    cfg_we <= 1'b0;
    n = 0;
    while (owed_blocks.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (owed_blocks.size() != 0) begin
      flag("blocks never delivered", owed_blocks.size(), 0);
      owed_blocks.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [SHIFT_W-1:0] sh, input int n);
    logic [DIM_W-1:0] sh_word;
    // sometimes put junk above the four shift bits
    sh_word = ($urandom_range(0, 3) == 0) ? {9'($urandom()), sh} : DIM_W'(sh);
    settle_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_BLOCK_SHIFT, sh_word);
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_SPARE, DIM_W'($urandom()));
    repeat (n) send_pixel(pixel_t'($urandom()), 1'b0, '0);
  endtask

  // Result scoreboard
  task automatic check_block(input result_t got);
    result_t want;
    if (owed_blocks.size() == 0) begin
      flag("result with nothing owed, column", got.out_column, 0);
    end else begin
      want = owed_blocks.pop_front();
      if (got.red_out != want.red_out)       flag("red_out", got.red_out, want.red_out);
      if (got.green_out != want.green_out)   flag("green_out", got.green_out, want.green_out);
      if (got.blue_out != want.blue_out)     flag("blue_out", got.blue_out, want.blue_out);
      if (got.alpha_out != want.alpha_out)   flag("alpha_out", got.alpha_out, want.alpha_out);
      if (got.out_column != want.out_column) flag("out_column", got.out_column, want.out_column);
      if (got.out_row != want.out_row)       flag("out_row", got.out_row, want.out_row);
      if (got.frame_done != want.frame_done) flag("frame_done", got.frame_done, want.frame_done);
    end
  endtask

  always @(posedge clk)
    if (!rst && result_ch.valid && result_ch.ready)
      check_block(result_ch.data);

  // Result sink: random back-pressure
  always @(negedge clk)
    result_ch.ready <= steady || ($urandom_range(0, 99) >= 26);

  function automatic step_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DIM_W-1:0] value);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.value = value;
    return s;
  endfunction

  function automatic step_t pix_row(input pixel_t px, input bit typed = 1'b0,
                                    input result_t want = '0);
    step_t s;
    s = '0;
    s.px = px;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  initial begin
    #(TIMEOUT_NS);
    $display("mipmap_box_downsample_top verification failed");
    $finish;
  end

  // Stimulus
  initial begin
    step_t script [$];
    int    sent;
    int    i;
    logic [SHIFT_W-1:0] sh;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    pixel_ch.valid = 1'b0;
    pixel_ch.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset defaults, 256 wide with shift 1: one source row, then the first two blocks
    repeat (260) send_pixel(pixel_t'($urandom()), 1'b0, '0);

    script = '{
      // 1x1 image, one-pixel blocks: each pixel returns as is and ends the frame
      reg_row(REG_IMAGE_WIDTH, 13'd1), reg_row(REG_IMAGE_HEIGHT, 13'd1),
      reg_row(REG_BLOCK_SHIFT, 13'd0),
      pix_row(32'h00000000, 1'b1, result_t'{8'h00, 8'h00, 8'h00, 8'h00, 12'd0, 12'd0, 1'b1}),
      pix_row(32'hffffffff, 1'b1, result_t'{8'hff, 8'hff, 8'hff, 8'hff, 12'd0, 12'd0, 1'b1}),
      pix_row(32'h55aa0ff0, 1'b1, result_t'{8'h55, 8'haa, 8'h0f, 8'hf0, 12'd0, 12'd0, 1'b1}),
      // 2x2 image, one 2x2 block: truncating average
      reg_row(REG_IMAGE_WIDTH, 13'd2), reg_row(REG_IMAGE_HEIGHT, 13'd2),
      reg_row(REG_BLOCK_SHIFT, 13'd1),
      pix_row(32'h0100ff03), pix_row(32'h0100ff03), pix_row(32'h0100ff03),
      pix_row(32'h0003ff03, 1'b1, result_t'{8'd0, 8'd0, 8'd255, 8'd3, 12'd0, 12'd0, 1'b1}),
      // half a block, then a write to the spare index restarts the frame
      pix_row(32'h07070707), pix_row(32'h09090909),
      reg_row(REG_SPARE, 13'd0),
      pix_row(32'h0ac800ff), pix_row(32'h14c80000), pix_row(32'h1ec800ff),
      pix_row(32'h28c80000, 1'b1, result_t'{8'd25, 8'd200, 8'd0, 8'd127, 12'd0, 12'd0, 1'b1}),
      // zero size reads as 1: smaller than a block, no result
      reg_row(REG_IMAGE_WIDTH, 13'd0), reg_row(REG_IMAGE_HEIGHT, 13'd0),
      pix_row(32'h12345678), pix_row(32'h9abcdef0),
      // 4x2 with shift 1: two blocks side by side
      reg_row(REG_IMAGE_WIDTH, 13'd4), reg_row(REG_IMAGE_HEIGHT, 13'd2),
      pix_row(32'hdeadbeef), pix_row(32'h01234567), pix_row(32'h89abcdef),
      pix_row(32'hfedcba98), pix_row(32'h76543210), pix_row(32'hc001d00d),
      pix_row(32'h80808080), pix_row(32'h7f7f7f7f)
    };

    for (i = 0; i < script.size(); i++) begin
      if (script[i].is_cfg) begin
        if (i == 0 || !script[i-1].is_cfg)
          settle_idle();
        write_reg(script[i].idx, script[i].value);
      end else begin
        send_pixel(script[i].px, script[i].typed, script[i].want);
      end
    end

    // Random phases: mostly small images and shifts, some oversized shifts
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      if ($urandom_range(0, 9) < 8) begin
        sh = SHIFT_W'($urandom_range(0, 3));
        i = $urandom_range(20, 120);
        run_phase(DIM_W'($urandom_range(0, 40)), DIM_W'($urandom_range(0, 20)), sh, i);
      end else begin
        sh = SHIFT_W'($urandom_range(4, 15));
        i = $urandom_range(10, 30);
        run_phase(DIM_W'($urandom()), DIM_W'($urandom_range(0, 20)), sh, i);
      end
      sent += i;
    end

    // Long run with no idling: every pixel closes a block, frames wrap
    steady = 1'b1;
    run_phase(13'd40, 13'd3, 4'd0, 120);
    steady = 1'b0;
    // Largest shift, image smaller than one block
    run_phase(13'd3, 13'd2, 4'd8, 16);

    settle_idle();
    if (mismatches == 0)
      $display("mipmap_box_downsample_top verification clean");
    else
      $display("mipmap_box_downsample_top verification failed");
    $finish;
  end

endmodule
